/* hw/rtl/ntrk_pkg.sv */
// Shared types and constants for the note interval shortest tracker.
`timescale 1ns / 1ps
`default_nettype none

package ntrk_pkg;

   localparam int TICK_W      = 32;
   localparam int INDEX_W     = 6;
   localparam int COUNT_W     = 8;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 104;
   localparam int DIV_STEPS   = TICK_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);
   localparam int NOTE_SLOTS  = 64;
   localparam int SLOT_CMP_W  = 9;

   localparam logic [TICK_W-1:0] INITIAL_SHORTEST_RESET = 32'd50000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_COMMIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic eval;
      logic div_step;
      logic commit;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

endpackage

`default_nettype wire

/* hw/rtl/ntrk_ctrl.sv */
// Controller state machine: sequences capture, update, division and output.
`timescale 1ns / 1ps
`default_nettype none

module ntrk_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   input  ntrk_pkg::status_type status,
   output ntrk_pkg::cmd_type   cmd
);
   import ntrk_pkg::*;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic               out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            step_in  = '0;
            state_in = status.need_div ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ntrk_dp.sv */
// Datapath: tracker state, interval arithmetic, bit-serial divider, result register.
`timescale 1ns / 1ps
`default_nettype none

module ntrk_dp (
   input  wire                                clock,
   input  wire                                reset,
   input  ntrk_pkg::cmd_type                  cmd,
   output ntrk_pkg::status_type               status,
   input  wire [ntrk_pkg::TICK_W-1:0]         in_timestamp,
   input  wire [ntrk_pkg::INDEX_W-1:0]        in_note_index,
   input  wire                                cfg_wr_en,
   input  wire [ntrk_pkg::TICK_W-1:0]         cfg_wr_data,
   output logic                               out_interval_valid,
   output logic [ntrk_pkg::INDEX_W-1:0]       out_interval_slot,
   output logic [ntrk_pkg::TICK_W-1:0]        out_interval,
   output logic [ntrk_pkg::TICK_W-1:0]        out_shortest_average,
   output logic [ntrk_pkg::TICK_W-1:0]        out_total_time
);
   import ntrk_pkg::*;

   localparam logic [SLOT_CMP_W-1:0] SLOT_LIMIT = SLOT_CMP_W'(NOTE_SLOTS);

   logic [TICK_W-1:0]  init_short_ff;
   logic [TICK_W-1:0]  ts_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [TICK_W-1:0]  last_tick_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [TICK_W-1:0]  sum_ff;
   logic [TICK_W-1:0]  est_ff;
   logic [TICK_W-1:0]  total_ff;
   logic [TICK_W-1:0]  quo_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [TICK_W-1:0]  res_interval_ff;
   logic [INDEX_W-1:0] res_slot_ff;
   logic               res_valid_ff;

   logic [TICK_W-1:0]  t_w;
   logic [TICK_W:0]    t15_w;
   logic [TICK_W:0]    e15_w;
   logic               is_start_w;
   logic               below_w;
   logic               restart_w;
   logic               add_w;
   logic [COUNT_W-1:0] cnt_base_w;
   logic [COUNT_W-1:0] cnt_next_w;
   logic [TICK_W-1:0]  sum_base_w;
   logic [TICK_W-1:0]  sum_next_w;
   logic [INDEX_W-1:0] slot_w;
   logic [COUNT_W:0]   trial_w;
   logic               trial_ge_w;
   logic [COUNT_W:0]   trial_diff_w;

   always_comb begin
      is_start_w = (idx_ff == '0);
      t_w        = ts_ff - last_tick_ff;
      t15_w      = {1'b0, t_w} + {2'b00, t_w[TICK_W-1:1]};
      e15_w      = {1'b0, est_ff} + {2'b00, est_ff[TICK_W-1:1]};
      below_w    = (t_w < est_ff);
      restart_w  = below_w && (t15_w < {1'b0, est_ff});
      add_w      = below_w || ({1'b0, t_w} < e15_w);
      cnt_base_w = restart_w ? '0 : count_ff;
      sum_base_w = restart_w ? '0 : sum_ff;
      // The count holds at its maximum so the divisor never wraps to zero.
      cnt_next_w = (cnt_base_w == '1) ? cnt_base_w : cnt_base_w + 1'b1;
      sum_next_w = sum_base_w + t_w;
      slot_w     = idx_ff - 1'b1;
      status.need_div = !is_start_w && add_w;
   end

   // One restoring division step: remainder stays below the 8-bit divisor.
   always_comb begin
      trial_w      = {rem_ff, quo_ff[TICK_W-1]};
      trial_ge_w   = (trial_w >= {1'b0, count_ff});
      trial_diff_w = trial_w - {1'b0, count_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_short_ff <= INITIAL_SHORTEST_RESET;
         last_tick_ff  <= '0;
         count_ff      <= '0;
         sum_ff        <= '0;
         est_ff        <= '0;
         total_ff      <= '0;
      end else begin
         if (cfg_wr_en) begin
            init_short_ff <= cfg_wr_data;
         end
         if (cmd.eval) begin
            last_tick_ff <= ts_ff;
            if (is_start_w) begin
               total_ff <= '0;
               est_ff   <= init_short_ff;
               count_ff <= COUNT_W'(1);
            end else begin
               total_ff <= total_ff + t_w;
               if (add_w) begin
                  count_ff <= cnt_next_w;
                  sum_ff   <= sum_next_w;
               end
            end
         end
         if (cmd.commit) begin
            est_ff <= quo_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ts_ff  <= in_timestamp;
         idx_ff <= in_note_index;
      end
      if (cmd.eval) begin
         quo_ff <= sum_next_w;
         rem_ff <= '0;
         if (is_start_w) begin
            res_interval_ff <= '0;
            res_slot_ff     <= '0;
            res_valid_ff    <= 1'b0;
         end else begin
            res_interval_ff <= t_w;
            res_slot_ff     <= slot_w;
            res_valid_ff    <= ({{(SLOT_CMP_W-INDEX_W){1'b0}}, slot_w} < SLOT_LIMIT);
         end
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge_w ? trial_diff_w[COUNT_W-1:0] : trial_w[COUNT_W-1:0];
         quo_ff <= {quo_ff[TICK_W-2:0], trial_ge_w};
      end
      if (cmd.load_out) begin
         out_interval_valid   <= res_valid_ff;
         out_interval_slot    <= res_slot_ff;
         out_interval         <= res_interval_ff;
         out_shortest_average <= est_ff;
         out_total_time       <= total_ff;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/note_interval_shortest_tracker.sv */
// Top level of the note interval shortest tracker.
//
// Usage: each transaction on the req_ channel is one note event, with the
// tick timestamp and the note index packed in req_tdata. Index zero starts a
// recording; any other index measures the interval since the last event and
// may refine the running estimate of the shortest interval.
// Exactly one result transaction leaves on the rsp_ channel per event.
// An event that updates the estimate passes through the update, the
// bit-serial divider, the commit and the output load before rsp_tvalid
// rises; any other event goes from the update to the output load, which
// waits until the output register is free. req_tready returns with
// rsp_tvalid after the output load, so one event is in flight at a time.
// csr_wr_en with csr_wr_data sets the estimate loaded at a recording start;
// the user writes it only while no event is in flight; the block does not
// enforce this. Reset clears all tracker state and sets that register to 50000.
// The result waits in an output register while rsp_tready is low, and the
// block still accepts and processes the next event; that event's result is
// held back until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module note_interval_shortest_tracker (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // timestamp [31:0], note_index [37:32], zero pad [39:38]
   input  wire [ntrk_pkg::REQ_DATA_W-1:0]       req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // interval_slot [5:0], interval [37:6], shortest_average [69:38],
   // total_time [101:70], zero pad [103:102]
   output logic [ntrk_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // interval_valid [0]
   output logic                                 rsp_tuser,
   input  wire                                  csr_wr_en,
   input  wire [ntrk_pkg::TICK_W-1:0]           csr_wr_data
);
   import ntrk_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [INDEX_W-1:0] out_slot;
   logic [TICK_W-1:0]  out_interval;
   logic [TICK_W-1:0]  out_average;
   logic [TICK_W-1:0]  out_total;

   ntrk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ntrk_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .in_timestamp         (req_tdata[TICK_W-1:0]),
      .in_note_index        (req_tdata[TICK_W+INDEX_W-1:TICK_W]),
      .cfg_wr_en            (csr_wr_en),
      .cfg_wr_data          (csr_wr_data),
      .out_interval_valid   (rsp_tuser),
      .out_interval_slot    (out_slot),
      .out_interval         (out_interval),
      .out_shortest_average (out_average),
      .out_total_time       (out_total)
   );

   assign rsp_tdata = {2'b00, out_total, out_average, out_interval, out_slot};

endmodule

`default_nettype wire
